FILE: hdl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types, constants and helpers for the wildcard byte pattern search.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int DEF_MAX_PATTERN = 32;
    localparam int DEF_COUNT_WIDTH = 32;
    localparam int ADDR_W          = 64;
    localparam int CFG_WORD_W      = 64;
    localparam int CFG_INDEX_W     = 3;
    localparam int PATTERN_WORDS   = 4;
    localparam int PATTERN_BITS    = PATTERN_WORDS * CFG_WORD_W;
    localparam int PATTERN_BYTES   = PATTERN_BITS / 8;
    localparam int LENGTH_W        = 6;

    localparam logic [7:0] WILDCARD = 8'h3F;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_0_7   = 3'd0,
        REG_PATTERN_8_15  = 3'd1,
        REG_PATTERN_16_23 = 3'd2,
        REG_PATTERN_24_31 = 3'd3,
        REG_PATTERN_LEN   = 3'd4,
        REG_REGION_BASE   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [PATTERN_BITS-1:0] pattern;
        logic [LENGTH_W-1:0]     length;
        logic [ADDR_W-1:0]       base;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } out_beat_t;

    // Pattern byte i; positions beyond the configured words read as zero.
    function automatic logic [7:0] pattern_byte(input logic [PATTERN_BITS-1:0] pattern,
                                                input int i);
        logic [7:0] b;
        b = 8'h00;
        if (i < PATTERN_BYTES) begin
            b = pattern[8*i +: 8];
        end
        return b;
    endfunction

endpackage

FILE: hdl/wbps_cfg_regs.sv
// ----------------------------------------------------------------------------
// wbps_cfg_regs
// Configuration register file: pattern words, pattern length, region base.
// ----------------------------------------------------------------------------
module wbps_cfg_regs import wbps_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_WORD_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    logic [PATTERN_BITS-1:0] pattern_reg, pattern_next;
    logic [LENGTH_W-1:0]     length_reg, length_next;
    logic [ADDR_W-1:0]       base_reg, base_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        pattern_next = pattern_reg;
        length_next  = length_reg;
        base_next    = base_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_0_7:   pattern_next[0*CFG_WORD_W +: CFG_WORD_W] = cfg_data;
                REG_PATTERN_8_15:  pattern_next[1*CFG_WORD_W +: CFG_WORD_W] = cfg_data;
                REG_PATTERN_16_23: pattern_next[2*CFG_WORD_W +: CFG_WORD_W] = cfg_data;
                REG_PATTERN_24_31: pattern_next[3*CFG_WORD_W +: CFG_WORD_W] = cfg_data;
                REG_PATTERN_LEN:   length_next = cfg_data[LENGTH_W-1:0];
                REG_REGION_BASE:   base_next   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= '0;
            base_reg    <= '0;
        end else begin
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
            base_reg    <= base_next;
        end
    end

    assign cfg.pattern = pattern_reg;
    assign cfg.length  = length_reg;
    assign cfg.base    = base_reg;

endmodule

FILE: hdl/wbps_scan.sv
// ----------------------------------------------------------------------------
// wbps_scan
// Byte window, region counter and parallel wildcard compare of all positions.
// ----------------------------------------------------------------------------
module wbps_scan import wbps_pkg::*; #(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_beat_t  in_beat,
    input  cfg_t      cfg,
    output logic      res_valid,
    output out_beat_t res_beat
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0]             window_reg [MAX_PATTERN];
    logic [7:0]             window_next [MAX_PATTERN];
    logic [COUNT_WIDTH-1:0] count_reg, count_next, count_inc;
    logic                   reported_reg, reported_next;

    logic [7:0]             pat [MAX_PATTERN];
    logic [7:0]             aligned [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pos_ok;
    logic [LW-1:0]          len;
    logic [LW-1:0]          idx_full [MAX_PATTERN];
    logic                   seen_ok;
    logic                   hit;
    logic [COUNT_WIDTH-1:0] offset;

    always_comb begin
        if ({1'b0, cfg.length} > 7'(MAX_PATTERN)) begin
            len = LW'(MAX_PATTERN);
        end else begin
            len = LW'(cfg.length);
        end
    end

    always_comb begin
        window_next[0] = in_beat.data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            window_next[k] = window_reg[k-1];
        end
    end

    // Pattern reversed so that byte len-1-k lines up with window slot k.
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pat[k]      = pattern_byte(cfg.pattern, k);
            idx_full[k] = len - LW'(k) - LW'(1);
        end
        for (int k = 0; k < MAX_PATTERN; k++) begin
            aligned[k] = pat[idx_full[k][IW-1:0]];
            pos_ok[k]  = (LW'(k) >= len) || (aligned[k] == WILDCARD) ||
                         (aligned[k] == window_next[k]);
        end
    end

    assign count_inc = (&count_reg) ? count_reg : count_reg + COUNT_WIDTH'(1);
    assign seen_ok   = (count_inc >= COUNT_WIDTH'(len));
    assign hit       = !reported_reg && seen_ok && (&pos_ok);
    assign offset    = (len == '0) ? '0 : count_inc - COUNT_WIDTH'(len);

    always_comb begin
        res_valid              = hit || (!reported_reg && in_beat.last_byte);
        res_beat.found         = hit;
        res_beat.match_address = hit ? cfg.base + ADDR_W'(offset) : '0;
    end

    always_comb begin
        count_next    = count_reg;
        reported_next = reported_reg;
        if (step) begin
            if (in_beat.last_byte) begin
                count_next    = '0;
                reported_next = 1'b0;
            end else begin
                count_next    = count_inc;
                reported_next = reported_reg || hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            reported_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            reported_reg <= reported_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            window_reg <= window_next;
        end
    end

endmodule

FILE: hdl/wildcard_byte_pattern_search_top.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_top
// Streams a region byte by byte and reports the first wildcard pattern match.
//
//  channel  ports                          beat
//  input    s_valid s_ready s_data         one region byte, last-byte flag
//  result   m_valid m_ready m_data         found flag, match address
//  config   cfg_valid cfg_ready cfg_index  register index, 64-bit write data
//           cfg_data
//
// One byte per cycle while s_ready is high; a result shows on m_* in the cycle
// after the causing byte, via the window compare, address add and result reg.
// Reset is synchronous, active low; no clearing pass, ready right after reset.
// s_ready drops only while a result is held and m_ready is low.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_top import wbps_pkg::*; #(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_beat_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_beat_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_WORD_W-1:0]  cfg_data
);

    cfg_t      cfg;
    logic      step;
    logic      res_valid;
    out_beat_t res_beat;
    logic      out_valid_reg, out_valid_next;
    out_beat_t out_data_reg;

    wbps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wbps_scan #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_beat   (s_data),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_beat  (res_beat)
    );

    assign s_ready = !out_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    always_comb begin
        if (step) begin
            out_valid_next = res_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            out_data_reg <= res_beat;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
